// ===== hdl/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants of the dual stepper pulse generator
// Op codes, field widths and the per-channel command struct.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int unsigned ChannelsDef = 2;
  localparam int unsigned OpW         = 3;
  localparam int unsigned StepsW      = 32;
  localparam int unsigned DelayW      = 16;
  localparam int unsigned MaskW       = 2;
  localparam int unsigned NumRegs     = 2;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [DelayW-1:0] DelayReset   = 16'd50;
  localparam logic [DelayW-1:0] DelayInvalid = 16'hFFFF;

  typedef enum logic [OpW-1:0] {
    OP_TICK       = 3'd0,
    OP_LOAD       = 3'd1,
    OP_LOAD_SAFE  = 3'd2,
    OP_LOAD_UNTIL = 3'd3,
    OP_START      = 3'd4,
    OP_STOP       = 3'd5
  } op_e;

  // command to one channel, decoded from a request
  typedef struct packed {
    logic              tick;
    logic              limit;
    logic              load;
    logic              safe;
    logic              to_limit;
    logic [StepsW-1:0] steps;
    logic              start;
    logic              stop;
  } chan_cmd_t;

  // registered input request
  typedef struct packed {
    logic [OpW-1:0]    op;
    logic              channel;
    logic [StepsW-1:0] steps;
    logic [MaskW-1:0]  channel_mask;
    logic              limit_a;
    logic              limit_b;
  } in_item_t;

  // registered result
  typedef struct packed {
    logic ok;
    logic step_pin_a;
    logic step_pin_b;
    logic moving_a;
    logic moving_b;
  } out_item_t;

endpackage

// ===== hdl/dsp_if.sv =====
// ----------------------------------------------------------------------------
// dsp_in_if / dsp_out_if: request and result channels
// Valid/ready channels carrying the request fields and the result fields.
// ----------------------------------------------------------------------------
interface dsp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        channel;
  logic [31:0] steps;
  logic [1:0]  channel_mask;
  logic        limit_a;
  logic        limit_b;

  modport source (output valid, op, channel, steps, channel_mask, limit_a, limit_b,
                  input ready);
  modport sink (input valid, op, channel, steps, channel_mask, limit_a, limit_b,
                output ready);
endinterface

interface dsp_out_if;
  logic valid;
  logic ready;
  logic ok;
  logic step_pin_a;
  logic step_pin_b;
  logic moving_a;
  logic moving_b;

  modport source (output valid, ok, step_pin_a, step_pin_b, moving_a, moving_b,
                  input ready);
  modport sink (input valid, ok, step_pin_a, step_pin_b, moving_a, moving_b,
                output ready);
endinterface

// ===== hdl/dsp_channel.sv =====
// ----------------------------------------------------------------------------
// dsp_channel: state and update logic of one step channel
// Holds the delay register, delay and step counters and the step pin level.
// ----------------------------------------------------------------------------
module dsp_channel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dsp_pkg::chan_cmd_t        cmd_i,
  input  logic                      cfg_we_i,
  input  logic [dsp_pkg::DelayW-1:0] cfg_wdata_i,
  output logic                      running_next_o,
  output logic                      step_level_next_o
);
  import dsp_pkg::*;

  logic              running_q, running_d;
  logic [DelayW-1:0] delay_left_q, delay_left_d;
  logic [StepsW-1:0] steps_left_q, steps_left_d;
  logic              next_high_q, next_high_d;
  logic              until_q, until_d;
  logic              stop_lim_q, stop_lim_d;
  logic              level_q, level_d;
  logic [DelayW-1:0] delay_reg_q, delay_reg_d;
  logic              run_lim, run_cnt;

  // limit and end-of-move checks for a tick
  always_comb begin
    run_lim = running_q;
    if (running_q && (stop_lim_q || until_q)) begin
      run_lim = !cmd_i.limit;
    end
    run_cnt = run_lim && !(!until_q && !next_high_q && (steps_left_q == '0));
  end

  // next state
  always_comb begin
    running_d    = running_q;
    delay_left_d = delay_left_q;
    steps_left_d = steps_left_q;
    next_high_d  = next_high_q;
    until_d      = until_q;
    stop_lim_d   = stop_lim_q;
    level_d      = level_q;
    delay_reg_d  = delay_reg_q;

    if (cfg_we_i && !running_q && (cfg_wdata_i != DelayInvalid)) begin
      delay_reg_d = cfg_wdata_i;
    end

    if (cmd_i.tick) begin
      running_d = run_cnt;
      if (run_cnt) begin
        if (delay_left_q == '0) begin
          if (next_high_q) begin
            level_d     = 1'b1;
            next_high_d = 1'b0;
          end else begin
            level_d     = 1'b0;
            next_high_d = 1'b1;
            if (!until_q) begin
              steps_left_d = steps_left_q - 1'b1;
            end
          end
          delay_left_d = delay_reg_q;
        end else begin
          delay_left_d = delay_left_q - 1'b1;
        end
      end
    end

    if (cmd_i.load) begin
      steps_left_d = cmd_i.to_limit ? '0 : cmd_i.steps;
      next_high_d  = 1'b0;
      until_d      = cmd_i.to_limit;
      stop_lim_d   = cmd_i.safe;
    end

    if (cmd_i.start) begin
      delay_left_d = '0;
      running_d    = 1'b1;
    end

    if (cmd_i.stop) begin
      running_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      delay_left_q <= '0;
      steps_left_q <= '0;
      next_high_q  <= 1'b0;
      until_q      <= 1'b0;
      stop_lim_q   <= 1'b1;
      level_q      <= 1'b0;
      delay_reg_q  <= DelayReset;
    end else begin
      running_q    <= running_d;
      delay_left_q <= delay_left_d;
      steps_left_q <= steps_left_d;
      next_high_q  <= next_high_d;
      until_q      <= until_d;
      stop_lim_q   <= stop_lim_d;
      level_q      <= level_d;
      delay_reg_q  <= delay_reg_d;
    end
  end

  assign running_next_o    = running_d;
  assign step_level_next_o = level_d;

  // an idle channel never moves its pin
  a_idle_pin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |=> $stable(level_q))
    else $error("step pin changed on an idle channel");

  // an until-limit move never carries a step count
  a_until_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    until_q |-> (steps_left_q == '0))
    else $error("until-limit move holds a step count");

  // a start always leaves the channel running
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start && !cmd_i.stop |=> running_q)
    else $error("started channel is not running");

endmodule

// ===== hdl/dual_stepper_pulse_generator_core.sv =====
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_core: two-channel step pulse generator
// Decodes tick and command requests and drives the per-channel step logic.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one request per handshake: a timer tick with the limit
//   switch levels, or a load / start / stop command. out_if returns exactly
//   one result per request: the ok flag and the step pin and moving levels
//   after the request took effect.
//   The request is registered in the input register, then decoded and
//   applied to the channel state as the result register is loaded. A new
//   request is taken in every cycle while the receiver takes the results,
//   one request per cycle sustained.
//   The delay registers are written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i while no request is in flight; a write to a running channel
//   or of the all-ones value is dropped.
//   After reset all channels are stopped, pins low, delays at 50 ticks.
//   When the receiver stalls the result register holds; one more request
//   waits in the input register, then in_if.ready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator_core #(
  parameter int unsigned CHANNELS = dsp_pkg::ChannelsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dsp_in_if.sink                      in_if,
  dsp_out_if.source                   out_if,
  input  logic                        cfg_we_i,
  input  logic [dsp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dsp_pkg::DelayW-1:0]  cfg_wdata_i
);
  import dsp_pkg::*;

  localparam int unsigned PadCh = (CHANNELS > 2) ? CHANNELS : 2;
  localparam logic [MaskW-1:0] ValidMask = (CHANNELS >= 2) ? 2'b11 : 2'b01;

  logic      s0_valid_q;
  in_item_t  s0_q;
  logic      s0_adv;
  logic      out_valid_q;
  out_item_t out_q;
  logic      ok;
  logic      is_load;

  logic [CHANNELS-1:0] run_cur, run_next, level_next;
  logic [PadCh-1:0]    run_pad, run_next_pad, level_next_pad;
  logic [PadCh-1:0]    mask_pad;

  // input register
  assign s0_adv      = s0_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s0_valid_q || s0_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s0_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      s0_q.op           <= in_if.op;
      s0_q.channel      <= in_if.channel;
      s0_q.steps        <= in_if.steps;
      s0_q.channel_mask <= in_if.channel_mask;
      s0_q.limit_a      <= in_if.limit_a;
      s0_q.limit_b      <= in_if.limit_b;
    end
  end

  assign run_pad        = PadCh'(run_cur);
  assign run_next_pad   = PadCh'(run_next);
  assign level_next_pad = PadCh'(level_next);
  assign mask_pad       = PadCh'(s0_q.channel_mask);

  // request decode and acceptance
  always_comb begin
    ok      = 1'b0;
    is_load = 1'b0;
    unique case (op_e'(s0_q.op)) inside
      OP_TICK: ok = 1'b1;
      OP_LOAD, OP_LOAD_SAFE, OP_LOAD_UNTIL: begin
        is_load = 1'b1;
        ok = ((CHANNELS >= 2) || !s0_q.channel) && !run_pad[s0_q.channel];
      end
      OP_START: begin
        ok = ((s0_q.channel_mask & ~ValidMask) == '0) &&
             !(s0_q.channel_mask[0] && run_pad[0]) &&
             !(s0_q.channel_mask[1] && run_pad[1]);
      end
      OP_STOP: ok = ((s0_q.channel_mask & ~ValidMask) == '0);
      default: ok = 1'b0;
    endcase
  end

  // channel instances
  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    chan_cmd_t cmd;
    logic      cfg_we;
    logic      running_q;

    always_comb begin
      cmd.tick     = s0_adv && (s0_q.op == OP_TICK);
      cmd.limit    = (c == 0) ? s0_q.limit_a : ((c == 1) ? s0_q.limit_b : 1'b0);
      cmd.load     = s0_adv && ok && is_load && (c < 2) && (32'(s0_q.channel) == c);
      cmd.safe     = (s0_q.op != OP_LOAD);
      cmd.to_limit = (s0_q.op == OP_LOAD_UNTIL);
      cmd.steps    = s0_q.steps;
      cmd.start    = s0_adv && ok && (s0_q.op == OP_START) && (c < 2) && mask_pad[c];
      cmd.stop     = s0_adv && ok && (s0_q.op == OP_STOP) && (c < 2) && mask_pad[c];
    end

    assign cfg_we = cfg_we_i && (c < NumRegs) && (32'(cfg_idx_i) == c);

    dsp_channel u_ch (
      .clk_i             (clk_i),
      .rst_ni            (rst_ni),
      .cmd_i             (cmd),
      .cfg_we_i          (cfg_we),
      .cfg_wdata_i       (cfg_wdata_i),
      .running_next_o    (run_next[c]),
      .step_level_next_o (level_next[c])
    );

    // mirror of the channel run flag for acceptance checks
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        running_q <= 1'b0;
      end else begin
        running_q <= run_next[c];
      end
    end
    assign run_cur[c] = running_q;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s0_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      out_q.ok         <= ok;
      out_q.step_pin_a <= level_next_pad[0];
      out_q.step_pin_b <= level_next_pad[1];
      out_q.moving_a   <= run_next_pad[0];
      out_q.moving_b   <= run_next_pad[1];
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.ok         = out_q.ok;
  assign out_if.step_pin_a = out_q.step_pin_a;
  assign out_if.step_pin_b = out_q.step_pin_b;
  assign out_if.moving_a   = out_q.moving_a;
  assign out_if.moving_b   = out_q.moving_b;

  // a tick is always acknowledged
  a_tick_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_adv && (s0_q.op == OP_TICK) |=> out_if.ok)
    else $error("tick result not ok");

  // codes past the stop command are refused
  a_bad_op_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_adv && (s0_q.op > OP_STOP) |=> !out_if.ok)
    else $error("unknown op accepted");

  // a pending request is never dropped while the result is stalled
  a_pending_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !s0_adv |=> s0_valid_q)
    else $error("pending request lost");

  // a refused start leaves the run flags alone
  a_refused_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_adv && (s0_q.op == OP_START) && !ok |=> $stable(run_cur))
    else $error("refused start changed a channel");

endmodule

// ===== verif/dual_stepper_pulse_generator_checker.sv =====
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_checker: status checker of the pulse generator
// Watches the request, result and delay write ports, keeps its own copy of
// both channels, predicts the status after every request and compares.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dsp_in_if                           req_ch,
  dsp_out_if                          res_ch,
  input  logic                        cfg_we_i,
  input  logic [dsp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dsp_pkg::DelayW-1:0]  cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import dsp_pkg::*;

  localparam int unsigned Chans = ChannelsDef;
  localparam logic [MaskW-1:0] ValidMask = (Chans >= 2) ? 2'b11 : 2'b01;

  // shadow channel state
  logic [Chans-1:0]  running_q;
  logic [Chans-1:0]  next_high_q;
  logic [Chans-1:0]  until_q;
  logic [Chans-1:0]  stop_lim_q;
  logic [Chans-1:0]  level_q;
  logic [DelayW-1:0] delay_left_q [Chans];
  logic [DelayW-1:0] delay_reg_q  [Chans];
  logic [StepsW-1:0] steps_left_q [Chans];

  out_item_t predicted_status [$];
  out_item_t want_st;
  out_item_t got_st;
  int        errors;

  // one tick of one channel: limit, end of move, then delay countdown
  function automatic void advance_channel(int c, logic lim);
    if (running_q[c] && (stop_lim_q[c] || until_q[c])) running_q[c] = !lim;
    if (running_q[c] && !until_q[c] && !next_high_q[c] && steps_left_q[c] == '0) begin
      running_q[c] = 1'b0;
    end
    if (!running_q[c]) return;
    if (delay_left_q[c] == '0) begin
      if (next_high_q[c]) begin
        level_q[c]     = 1'b1;
        next_high_q[c] = 1'b0;
      end else begin
        level_q[c]     = 1'b0;
        next_high_q[c] = 1'b1;
        if (!until_q[c]) steps_left_q[c] = steps_left_q[c] - 1'b1;
      end
      delay_left_q[c] = delay_reg_q[c];
    end else begin
      delay_left_q[c] = delay_left_q[c] - 1'b1;
    end
  endfunction

  // load a move into an idle channel
  function automatic logic arm_move(int c, logic [StepsW-1:0] steps, logic safe,
                                    logic to_limit);
    if (c >= Chans || running_q[c]) return 1'b0;
    steps_left_q[c] = to_limit ? '0 : steps;
    next_high_q[c]  = 1'b0;
    until_q[c]      = to_limit;
    stop_lim_q[c]   = safe;
    return 1'b1;
  endfunction

  // apply one request to the shadow state and return the status after it
  function automatic out_item_t predict_status(logic [OpW-1:0] op, logic ch,
                                               logic [StepsW-1:0] steps,
                                               logic [MaskW-1:0] mask,
                                               logic lim_a, logic lim_b);
    out_item_t st;
    logic ok;
    logic [1:0] lim;
    ok  = 1'b1;
    lim = {lim_b, lim_a};
    case (op)
      OP_TICK: begin
        for (int c = 0; c < Chans; c++) advance_channel(c, (c < 2) ? lim[c] : 1'b0);
      end
      OP_LOAD:       ok = arm_move(ch, steps, 1'b0, 1'b0);
      OP_LOAD_SAFE:  ok = arm_move(ch, steps, 1'b1, 1'b0);
      OP_LOAD_UNTIL: ok = arm_move(ch, steps, 1'b1, 1'b1);
      OP_START: begin
        if ((mask & ~ValidMask) != '0) begin
          ok = 1'b0;
        end else begin
          for (int c = 0; c < 2; c++) if (mask[c] && running_q[c]) ok = 1'b0;
          if (ok) begin
            for (int c = 0; c < 2; c++) begin
              if (mask[c]) begin
                delay_left_q[c] = '0;
                running_q[c]    = 1'b1;
              end
            end
          end
        end
      end
      OP_STOP: begin
        if ((mask & ~ValidMask) != '0) begin
          ok = 1'b0;
        end else begin
          for (int c = 0; c < 2; c++) if (mask[c]) running_q[c] = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
    st.ok         = ok;
    st.step_pin_a = level_q[0];
    st.step_pin_b = level_q[1];
    st.moving_a   = running_q[0];
    st.moving_b   = running_q[1];
    return st;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      errors++;
    end
  endfunction

  // track writes, results and requests at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   = '0;
      next_high_q = '0;
      until_q     = '0;
      stop_lim_q  = '1;
      level_q     = '0;
      for (int c = 0; c < Chans; c++) begin
        delay_left_q[c] = '0;
        steps_left_q[c] = '0;
        delay_reg_q[c]  = DelayReset;
      end
      predicted_status.delete();
      errors = 0;
    end else begin
      // delay register write, dropped while running or for all ones
      if (cfg_we_i && cfg_idx_i < NumRegs && cfg_idx_i < Chans) begin
        if (!running_q[cfg_idx_i] && cfg_wdata_i != DelayInvalid) begin
          delay_reg_q[cfg_idx_i] = cfg_wdata_i;
        end
      end
      // result against the oldest prediction
      if (res_ch.valid && res_ch.ready) begin
        got_st.ok         = res_ch.ok;
        got_st.step_pin_a = res_ch.step_pin_a;
        got_st.step_pin_b = res_ch.step_pin_b;
        got_st.moving_a   = res_ch.moving_a;
        got_st.moving_b   = res_ch.moving_b;
        if (predicted_status.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          want_st = predicted_status.pop_front();
          check_field("ok", want_st.ok, got_st.ok);
          check_field("step_pin_a", want_st.step_pin_a, got_st.step_pin_a);
          check_field("step_pin_b", want_st.step_pin_b, got_st.step_pin_b);
          check_field("moving_a", want_st.moving_a, got_st.moving_a);
          check_field("moving_b", want_st.moving_b, got_st.moving_b);
        end
      end
      // accepted request
      if (req_ch.valid && req_ch.ready) begin
        predicted_status.push_back(predict_status(req_ch.op, req_ch.channel, req_ch.steps,
                                                  req_ch.channel_mask, req_ch.limit_a,
                                                  req_ch.limit_b));
      end
    end
    fail_count_o <= errors;
    pending_o    <= predicted_status.size();
  end

endmodule

// ===== verif/dual_stepper_pulse_generator_core_test.sv =====
// ----------------------------------------------------------------------------
// dual_stepper_pulse_generator_core_test: testbench of the pulse generator
// Directed requests over the corner cases, then phases of random moves and
// noise under several delay settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_generator_core_test;
  import dsp_pkg::*;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned Phases        = 10;
  localparam int unsigned PhaseItems    = 96;
  localparam logic [OpW-1:0] OpBadLo    = 3'd6;
  localparam logic [OpW-1:0] OpBadHi    = 3'd7;
  localparam logic [StepsW-1:0] StepsMax = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DelayW-1:0]  cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 sent_items = 0;
  bit                 idle_on = 1'b1;
  bit                 hold_off_req = 1'b0;

  dsp_in_if  req_ch ();
  dsp_out_if res_ch ();

  dual_stepper_pulse_generator_core #(
    .CHANNELS (ChannelsDef)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (req_ch),
    .out_if      (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  dual_stepper_pulse_generator_checker status_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_ch       (req_ch),
    .res_ch       (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // offer one request and wait for it to be taken, then maybe idle
  task automatic send_request(logic [OpW-1:0] op, logic ch, logic [StepsW-1:0] steps,
                              logic [MaskW-1:0] mask, logic lim_a, logic lim_b);
    req_ch.valid        <= 1'b1;
    req_ch.op           <= op;
    req_ch.channel      <= ch;
    req_ch.steps        <= steps;
    req_ch.channel_mask <= mask;
    req_ch.limit_a      <= lim_a;
    req_ch.limit_b      <= lim_b;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_items++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // tick with rarely active limit switches
  task automatic send_tick();
    send_request(OP_TICK, 1'($urandom), $urandom, 2'($urandom),
                 $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0);
  endtask

  // any op, any fields
  task automatic send_noise();
    send_request(3'($urandom_range(0, 7)), 1'($urandom), $urandom, 2'($urandom),
                 1'($urandom), 1'($urandom));
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_delay(logic [CfgIdxW-1:0] idx, logic [DelayW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [StepsW-1:0] pick_steps();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  // result side: random stall bursts and one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    int phase_end;
    int n;
    logic [DelayW-1:0] d0;
    logic [DelayW-1:0] d1;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_TICK;
    req_ch.channel      = 1'b0;
    req_ch.steps        = '0;
    req_ch.channel_mask = '0;
    req_ch.limit_a      = 1'b0;
    req_ch.limit_b      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases
    write_delay(1'b0, 16'd0);
    write_delay(1'b1, 16'd1);
    send_request(OP_TICK, 1'b0, '0, 2'b00, 1'b1, 1'b1);
    send_request(OpBadLo, 1'b1, StepsMax, 2'b11, 1'b0, 1'b0);
    send_request(OpBadHi, 1'b0, '0, 2'b01, 1'b1, 1'b0);
    send_request(OP_LOAD, 1'b0, 32'd2, 2'b10, 1'b0, 1'b0);
    send_request(OP_LOAD_SAFE, 1'b1, StepsMax, 2'b00, 1'b0, 1'b0);
    send_request(OP_START, 1'b0, '0, 2'b00, 1'b0, 1'b0);
    send_request(OP_START, 1'b1, '0, 2'b11, 1'b0, 1'b0);
    // refused while running
    send_request(OP_LOAD, 1'b0, 32'd5, 2'b00, 1'b0, 1'b0);
    send_request(OP_START, 1'b0, '0, 2'b01, 1'b0, 1'b0);
    // channel zero ignores its limit and runs out of steps
    repeat (6) send_request(OP_TICK, 1'b0, '0, 2'b00, 1'b1, 1'b0);
    // channel one stops on its limit
    send_request(OP_TICK, 1'b1, StepsMax, 2'b11, 1'b0, 1'b1);
    send_request(OP_STOP, 1'b0, '0, 2'b00, 1'b0, 1'b0);
    // until-limit move ignores steps, zero-step move stops at once
    send_request(OP_LOAD_UNTIL, 1'b1, StepsMax, 2'b00, 1'b0, 1'b0);
    send_request(OP_LOAD, 1'b0, '0, 2'b00, 1'b0, 1'b0);
    send_request(OP_START, 1'b0, '0, 2'b11, 1'b0, 1'b0);
    send_request(OP_TICK, 1'b0, '0, 2'b00, 1'b0, 1'b0);
    send_request(OP_TICK, 1'b0, '0, 2'b00, 1'b0, 1'b0);
    send_request(OP_TICK, 1'b0, '0, 2'b00, 1'b0, 1'b1);
    send_request(OP_STOP, 1'b1, StepsMax, 2'b11, 1'b1, 1'b1);

    // random phases, each under its own delay setting
    for (int phase = 0; phase < Phases; phase++) begin
      if (phase % 4 != 3) send_request(OP_STOP, 1'($urandom), $urandom, 2'b11, 1'b0, 1'b0);
      wait_drained();
      case (phase)
        0: begin d0 = 16'd0;        d1 = 16'd65534; end
        1: begin d0 = 16'd1;        d1 = 16'd2;     end
        2: begin d0 = DelayInvalid; d1 = 16'd3;     end
        4: begin d0 = 16'd65534;    d1 = 16'd65534; end
        default: begin
          d0 = ($urandom_range(0, 7) == 0) ? DelayInvalid : 16'($urandom_range(0, 4));
          d1 = ($urandom_range(0, 7) == 0) ? DelayInvalid : 16'($urandom_range(0, 4));
        end
      endcase
      write_delay(1'b0, d0);
      write_delay(1'b1, d1);
      idle_on = (phase != Phases - 1);

      // result side holds off while requests keep coming
      if (phase == 2) begin
        hold_off_req = 1'b1;
        repeat (40) send_tick();
      end

      phase_end = sent_items + PhaseItems;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 99) < 80) begin
          // load some channels, start, run ticks, maybe stop
          for (int c = 0; c < 2; c++) begin
            if ($urandom_range(0, 3) != 0) begin
              send_request(3'(OP_LOAD + $urandom_range(0, 2)), 1'(c), pick_steps(),
                           2'($urandom), 1'($urandom), 1'($urandom));
            end
          end
          send_request(OP_START, 1'($urandom), $urandom, 2'($urandom_range(1, 3)),
                       1'($urandom), 1'($urandom));
          n = $urandom_range(4, 30);
          repeat (n) begin
            if ($urandom_range(0, 15) == 0) send_noise();
            else send_tick();
          end
          if ($urandom_range(0, 1) == 0) begin
            send_request(OP_STOP, 1'($urandom), $urandom, 2'($urandom_range(0, 3)),
                         1'($urandom), 1'($urandom));
          end
        end else begin
          send_noise();
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
